>>> hw/rtl/sha_pkg.sv
// SHA-512 shared types, constants and round functions.
// Used by the front end, the compression core and the top level.
package sha_pkg;

    typedef logic [63:0] t_word;

    // classified transaction passed from front end to core
    typedef struct packed {
        t_word      word;
        logic       is_last;
        logic [3:0] count;
    } t_cmd;

    localparam int unsigned QUEUE_DEPTH = 4;
    localparam int unsigned QPTR_W      = 2;

    localparam t_word INIT_H [8] = '{
        64'h6a09e667f3bcc908, 64'hbb67ae8584caa73b, 64'h3c6ef372fe94f82b,
        64'ha54ff53a5f1d36f1, 64'h510e527fade682d1, 64'h9b05688c2b3e6c1f,
        64'h1f83d9abfb41bd6b, 64'h5be0cd19137e2179};

    localparam t_word ROUND_K [80] = '{
        64'h428a2f98d728ae22, 64'h7137449123ef65cd, 64'hb5c0fbcfec4d3b2f, 64'he9b5dba58189dbbc,
        64'h3956c25bf348b538, 64'h59f111f1b605d019, 64'h923f82a4af194f9b, 64'hab1c5ed5da6d8118,
        64'hd807aa98a3030242, 64'h12835b0145706fbe, 64'h243185be4ee4b28c, 64'h550c7dc3d5ffb4e2,
        64'h72be5d74f27b896f, 64'h80deb1fe3b1696b1, 64'h9bdc06a725c71235, 64'hc19bf174cf692694,
        64'he49b69c19ef14ad2, 64'hefbe4786384f25e3, 64'h0fc19dc68b8cd5b5, 64'h240ca1cc77ac9c65,
        64'h2de92c6f592b0275, 64'h4a7484aa6ea6e483, 64'h5cb0a9dcbd41fbd4, 64'h76f988da831153b5,
        64'h983e5152ee66dfab, 64'ha831c66d2db43210, 64'hb00327c898fb213f, 64'hbf597fc7beef0ee4,
        64'hc6e00bf33da88fc2, 64'hd5a79147930aa725, 64'h06ca6351e003826f, 64'h142929670a0e6e70,
        64'h27b70a8546d22ffc, 64'h2e1b21385c26c926, 64'h4d2c6dfc5ac42aed, 64'h53380d139d95b3df,
        64'h650a73548baf63de, 64'h766a0abb3c77b2a8, 64'h81c2c92e47edaee6, 64'h92722c851482353b,
        64'ha2bfe8a14cf10364, 64'ha81a664bbc423001, 64'hc24b8b70d0f89791, 64'hc76c51a30654be30,
        64'hd192e819d6ef5218, 64'hd69906245565a910, 64'hf40e35855771202a, 64'h106aa07032bbd1b8,
        64'h19a4c116b8d2d0c8, 64'h1e376c085141ab53, 64'h2748774cdf8eeb99, 64'h34b0bcb5e19b48a8,
        64'h391c0cb3c5c95a63, 64'h4ed8aa4ae3418acb, 64'h5b9cca4f7763e373, 64'h682e6ff3d6b2b8a3,
        64'h748f82ee5defb2fc, 64'h78a5636f43172f60, 64'h84c87814a1f0ab72, 64'h8cc702081a6439ec,
        64'h90befffa23631e28, 64'ha4506cebde82bde9, 64'hbef9a3f7b2c67915, 64'hc67178f2e372532b,
        64'hca273eceea26619c, 64'hd186b8c721c0c207, 64'heada7dd6cde0eb1e, 64'hf57d4f7fee6ed178,
        64'h06f067aa72176fba, 64'h0a637dc5a2c898a6, 64'h113f9804bef90dae, 64'h1b710b35131c471b,
        64'h28db77f523047d84, 64'h32caab7b40c72493, 64'h3c9ebe0a15c9bebc, 64'h431d67c49c100d4c,
        64'h4cc5d4becb3e42b6, 64'h597f299cfc657e2a, 64'h5fcb6fab3ad6faec, 64'h6c44198c4a475817};

    function automatic t_word ror64(input t_word v, input int unsigned n);
        ror64 = (v >> n) | (v << (64 - n));
    endfunction

    function automatic t_word sig0(input t_word x);
        sig0 = ror64(x, 1) ^ ror64(x, 8) ^ (x >> 7);
    endfunction

    function automatic t_word sig1(input t_word x);
        sig1 = ror64(x, 19) ^ ror64(x, 61) ^ (x >> 6);
    endfunction

endpackage

>>> hw/rtl/sha512_stream_hasher.sv
// SHA-512 stream hasher, top level.
// Depends on sha_pkg, sha_front and sha_core.
//
// Input channel: i_valid/o_stall with i_data_word (big-endian bytes),
// i_byte_count and i_last_word. A transaction is taken when i_valid is
// high and o_stall low. Byte count is used only on the last word
// (values above eight count as eight).
// Output channel: o_valid/i_stall; on each last word eight transactions
// give the digest words, index 0 first, o_last_digest_word on index 7.
// A four-entry queue separates intake from the compression core.
// Throughput is set by the single shared round unit: no word is taken
// from the queue while a block runs its rounds and the add. Padding
// may add a second block; the digest then leaves at one word a cycle
// while i_stall is low.
// Reset (synchronous, active low) empties the queue and loads the
// initial hash values. While i_stall is high the current digest word
// holds and the core waits; the queue fills and then o_stall rises.
module sha512_stream_hasher import sha_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [63:0] i_data_word,
    input  logic [3:0]  i_byte_count,
    input  logic        i_last_word,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [63:0] o_digest_word,
    output logic [2:0]  o_word_index,
    output logic        o_last_digest_word
);
    logic cmd_valid, cmd_pop;
    t_cmd cmd;

    sha_front u_front (
        .i_clk, .i_rst_n, .i_valid, .o_stall, .i_data_word, .i_byte_count,
        .i_last_word, .o_cmd_valid(cmd_valid), .o_cmd(cmd), .i_cmd_pop(cmd_pop));

    sha_core u_core (
        .i_clk, .i_rst_n, .i_cmd_valid(cmd_valid), .i_cmd(cmd), .o_cmd_pop(cmd_pop),
        .o_valid, .i_stall, .o_digest_word, .o_word_index, .o_last_digest_word);
endmodule

>>> hw/rtl/sha_front.sv
// Front end: accepts message transactions into a short queue.
// Depends on sha_pkg.
module sha_front import sha_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_stall,
    input  logic [63:0] i_data_word,
    input  logic [3:0] i_byte_count,
    input  logic       i_last_word,
    output logic       o_cmd_valid,
    output t_cmd       o_cmd,
    input  logic       i_cmd_pop
);
    t_cmd              r_mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0] r_wp, r_rp;
    logic [QPTR_W:0]   r_cnt;
    logic              push;
    logic [3:0]        sat;

    assign o_stall     = (r_cnt == 3'(QUEUE_DEPTH));
    assign push        = i_valid && !o_stall;
    assign o_cmd_valid = (r_cnt != '0);
    assign o_cmd       = r_mem[r_rp];
    // saturate count on last, force eight otherwise
    assign sat = !i_last_word ? 4'd8 : (i_byte_count > 4'd8 ? 4'd8 : i_byte_count);

    // store classified transaction
    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wp] <= '{word: i_data_word, is_last: i_last_word, count: sat};
        end
    end

    // advance pointers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp <= '0; r_rp <= '0; r_cnt <= '0;
        end else begin
            if (push) r_wp <= r_wp + 1'b1;
            if (i_cmd_pop) r_rp <= r_rp + 1'b1;
            r_cnt <= r_cnt + {2'b0, push} - {2'b0, i_cmd_pop};
        end
    end

    a_no_pop_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd_pop |-> o_cmd_valid) else $error("pop from empty queue");
    a_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= 3'(QUEUE_DEPTH)) else $error("queue count overflow");
    a_full_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_cnt == 3'(QUEUE_DEPTH)) |-> o_stall) else $error("no stall when full");
endmodule

>>> hw/rtl/sha_core.sv
// Back end: buffers words, pads, runs 80 rounds per block, emits digest.
// Depends on sha_pkg.
module sha_core import sha_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cmd_valid,
    input  t_cmd        i_cmd,
    output logic        o_cmd_pop,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [63:0] o_digest_word,
    output logic [2:0]  o_word_index,
    output logic        o_last_digest_word
);
    localparam logic [2:0] S_IDLE = 3'd0, S_PAD = 3'd1, S_RND = 3'd2,
                           S_ADD = 3'd3, S_OUT = 3'd4;

    logic [2:0]  r_st, n_st;
    t_word       r_w [16];
    t_word       r_h [8];
    t_word       r_v [8];
    logic [3:0]  r_fill;
    logic [60:0] r_len;
    logic [6:0]  r_rnd;
    logic        r_pad;     // padding in progress
    logic        r_fin;     // final block of message
    logic [2:0]  r_oidx;
    logic        r_mark;    // 0x80 still to be placed

    t_word       pw, wnew, t1, t2, a, e;
    logic        take, wr;
    t_word       keep;
    logic [5:0]  sh;

    assign o_valid            = (r_st == S_OUT);
    assign o_digest_word      = r_h[r_oidx];
    assign o_word_index       = r_oidx;
    assign o_last_digest_word = (r_oidx == 3'd7);
    assign take      = (r_st == S_IDLE) && i_cmd_valid;
    assign o_cmd_pop = take;

    // masked data, with end marker after a partial word
    always_comb begin
        sh   = 6'(56 - 8 * i_cmd.count);
        keep = (i_cmd.count == 4'd0) ? '0 : ~64'd0 << (7'd64 - 7'(8 * i_cmd.count));
        pw   = (i_cmd.count == 4'd8) ? i_cmd.word : ((i_cmd.word & keep) | (64'h80 << sh));
    end

    // word to write into the buffer: taken data, or padding for current fill
    always_comb begin
        wnew = '0;
        wr   = 1'b0;
        if (take) begin
            wnew = pw; wr = 1'b1;
        end else if (r_st == S_PAD) begin
            wr   = 1'b1;
            if (r_mark)               wnew = 64'h8000000000000000;
            else if (r_fin && r_fill == 4'd15) wnew = {r_len, 3'b000};
            else                       wnew = '0;
        end
    end

    // round datapath, schedule kept in a 16-word ring
    always_comb begin
        a  = r_v[0];
        e  = r_v[4];
        t1 = r_v[7] + (ror64(e, 14) ^ ror64(e, 18) ^ ror64(e, 41)) +
             ((e & r_v[5]) ^ (~e & r_v[6])) + ROUND_K[r_rnd] + r_w[0];
        t2 = (ror64(a, 28) ^ ror64(a, 34) ^ ror64(a, 39)) +
             ((a & r_v[1]) ^ (a & r_v[2]) ^ (r_v[1] & r_v[2]));
    end

    always_comb begin
        n_st = r_st;
        case (r_st)
            S_IDLE: if (take) begin
                if (r_fill == 4'd15) n_st = S_RND;
                else if (i_cmd.is_last) n_st = S_PAD;
            end
            S_PAD: if (r_fill == 4'd15) n_st = S_RND;
            S_RND: if (r_rnd == 7'd79) n_st = S_ADD;
            S_ADD: n_st = !r_fin ? (r_pad ? S_PAD : S_IDLE) : S_OUT;
            S_OUT: if (!i_stall && r_oidx == 3'd7) n_st = S_IDLE;
            default: n_st = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= S_IDLE; r_fill <= '0; r_len <= '0; r_rnd <= '0;
            r_pad <= 1'b0; r_fin <= 1'b0; r_oidx <= '0; r_mark <= 1'b0;
            for (int i = 0; i < 8; i++) r_h[i] <= INIT_H[i];
        end else begin
            r_st <= n_st;
            // buffer fill and padding control
            if (wr) begin
                r_w[r_fill] <= wnew;
                r_fill      <= r_fill + 1'b1;
                if (r_st == S_PAD) r_mark <= 1'b0;
            end
            if (take) begin
                r_len <= r_len + 61'(i_cmd.count);
                if (i_cmd.is_last) begin
                    r_pad  <= 1'b1;
                    r_mark <= (i_cmd.count == 4'd8);
                    // length fits in this block only if marker leaves two slots
                    r_fin  <= (r_fill <= 4'd13) && (i_cmd.count != 4'd8);
                end
            end
            if (r_st == S_PAD && wr && !r_mark && !r_fin && r_fill == 4'd15) begin
                r_fin <= 1'b0;
            end
            if (r_st == S_PAD && wr && r_mark) begin
                r_fin <= (r_fill <= 4'd13);
            end
            if (n_st == S_RND && r_st != S_RND) begin
                r_rnd <= '0;
                for (int i = 0; i < 8; i++) r_v[i] <= r_h[i];
            end
            // one round, slide schedule ring
            if (r_st == S_RND) begin
                r_v[7] <= r_v[6]; r_v[6] <= r_v[5]; r_v[5] <= e;
                r_v[4] <= r_v[3] + t1; r_v[3] <= r_v[2]; r_v[2] <= r_v[1];
                r_v[1] <= a; r_v[0] <= t1 + t2;
                r_rnd  <= r_rnd + 1'b1;
                for (int i = 0; i < 15; i++) r_w[i] <= r_w[i+1];
                r_w[15] <= r_w[0] + sig0(r_w[1]) + r_w[9] + sig1(r_w[14]);
            end
            if (r_st == S_ADD) begin
                for (int i = 0; i < 8; i++) r_h[i] <= r_h[i] + r_v[i];
                r_fill <= '0;
                if (!r_fin && r_pad) r_fin <= !r_mark;
            end
            // drain digest words
            if (r_st == S_OUT && !i_stall) begin
                r_oidx <= r_oidx + 1'b1;
                if (r_oidx == 3'd7) begin
                    for (int i = 0; i < 8; i++) r_h[i] <= INIT_H[i];
                    r_len <= '0; r_pad <= 1'b0; r_fin <= 1'b0;
                end
            end
        end
    end

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_stall) |=> (o_valid && $stable(r_oidx))) else $error("digest dropped");
    a_no_take_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd_pop |-> (r_st == S_IDLE)) else $error("pop while busy");
    a_rnd_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_st == S_RND) |-> (r_rnd <= 7'd79)) else $error("round overrun");
endmodule

>>> sim/tb_sha512_stream_hasher.sv
// Self-checking testbench for the SHA-512 stream hasher: directed table, boundary lengths, then random messages.
// Depends on sha_pkg (types, initial hash values, round constants) and the top level RTL.
`timescale 1ns / 100ps

module tb_sha512_stream_hasher;
    import sha_pkg::*;

    typedef struct {
        t_word      data;
        logic [3:0] count;
        logic       last;
        logic       has_digest0;
        t_word      digest0;
    } t_stim_row;

    typedef struct {
        t_word      word;
        logic [2:0] index;
        logic       last;
    } t_digest_beat;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_valid = 1'b0;
    logic        o_stall;
    logic [63:0] i_data_word = '0;
    logic [3:0]  i_byte_count = '0;
    logic        i_last_word = 1'b0;
    logic        o_valid;
    logic        i_stall = 1'b0;
    logic [63:0] o_digest_word;
    logic [2:0]  o_word_index;
    logic        o_last_digest_word;

    // sender and receiver idle percentages, changed per phase
    int unsigned send_idle_pct = 0;
    int unsigned recv_idle_pct = 0;
    int unsigned error_count = 0;

    // predictor state
    t_word      hash_state [8];
    t_word      block_words [16];
    int unsigned block_fill;
    logic [60:0] byte_total;

    t_digest_beat digest_queue [$];

    sha512_stream_hasher i_dut (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_valid            (i_valid),
        .o_stall            (o_stall),
        .i_data_word        (i_data_word),
        .i_byte_count       (i_byte_count),
        .i_last_word        (i_last_word),
        .o_valid            (o_valid),
        .i_stall            (i_stall),
        .o_digest_word      (o_digest_word),
        .o_word_index       (o_word_index),
        .o_last_digest_word (o_last_digest_word)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    task automatic report_mismatch(input string what, input t_word got, input t_word want);
        $display("tb: mismatch %s got %h want %h at %0t", what, got, want, $time);
        error_count++;
    endtask

    function automatic t_word rotr(input t_word v, input int unsigned n);
        return (v >> n) | (v << (64 - n));
    endfunction

    // run the 80-round compression over the buffered block
    function automatic void compress_block();
        t_word sched [80];
        t_word a, b, c, d, e, f, g, h, t1, t2;
        for (int i = 0; i < 16; i++) sched[i] = block_words[i];
        for (int i = 16; i < 80; i++)
            sched[i] = sched[i-16] + sched[i-7]
                     + (rotr(sched[i-15], 1) ^ rotr(sched[i-15], 8) ^ (sched[i-15] >> 7))
                     + (rotr(sched[i-2], 19) ^ rotr(sched[i-2], 61) ^ (sched[i-2] >> 6));
        a = hash_state[0]; b = hash_state[1]; c = hash_state[2]; d = hash_state[3];
        e = hash_state[4]; f = hash_state[5]; g = hash_state[6]; h = hash_state[7];
        for (int i = 0; i < 80; i++) begin
            t1 = h + (rotr(e, 14) ^ rotr(e, 18) ^ rotr(e, 41)) + ((e & f) ^ (~e & g))
               + ROUND_K[i] + sched[i];
            t2 = (rotr(a, 28) ^ rotr(a, 34) ^ rotr(a, 39)) + ((a & b) ^ (a & c) ^ (b & c));
            h = g; g = f; f = e; e = d + t1; d = c; c = b; b = a; a = t1 + t2;
        end
        hash_state[0] += a; hash_state[1] += b; hash_state[2] += c; hash_state[3] += d;
        hash_state[4] += e; hash_state[5] += f; hash_state[6] += g; hash_state[7] += h;
    endfunction

    function automatic void append_word(input t_word w);
        block_words[block_fill] = w;
        block_fill++;
        if (block_fill == 16) begin
            compress_block();
            block_fill = 0;
        end
    endfunction

    function automatic void restart_hash();
        for (int i = 0; i < 8; i++) hash_state[i] = INIT_H[i];
        block_fill = 0;
        byte_total = '0;
    endfunction

    // fold one accepted transaction into the hash; queue the digest on a last word
    function automatic void hash_word(input t_word data, input logic [3:0] count, input logic last);
        int unsigned n;
        t_word keep;
        t_digest_beat beat;
        if (!last) begin
            byte_total += 61'd8;
            append_word(data);
            return;
        end
        n = (count > 8) ? 8 : count;
        byte_total += 61'(n);
        if (n == 8) begin
            append_word(data);
            append_word(64'h80 << 56);
        end else begin
            keep = (n == 0) ? '0 : ~64'd0 << (64 - 8 * n);
            append_word((data & keep) | (64'h80 << (56 - 8 * n)));
        end
        if (block_fill > 14)
            while (block_fill != 0) append_word('0);
        while (block_fill < 14) append_word('0);
        append_word('0);
        append_word({byte_total, 3'b000});
        for (int k = 0; k < 8; k++) begin
            beat.word  = hash_state[k];
            beat.index = 3'(k);
            beat.last  = (k == 7);
            digest_queue.push_back(beat);
        end
        restart_hash();
    endfunction

    // drive one transaction and hold it until accepted; valid stays up for the next one
    task automatic send_word(input t_word data, input logic [3:0] count, input logic last);
        while (($urandom % 100) < send_idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid      <= 1'b1;
        i_data_word  <= data;
        i_byte_count <= count;
        i_last_word  <= last;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        hash_word(data, count, last);
    endtask

    task automatic send_message(input int unsigned words, input logic [3:0] last_count);
        for (int i = 0; i < words; i++)
            send_word({$urandom, $urandom}, 4'($urandom), 1'b0);
        send_word({$urandom, $urandom}, last_count, 1'b1);
    endtask

    // drop valid, then wait for every expected digest word
    task automatic wait_drained();
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (digest_queue.size() != 0) @(posedge i_clk);
    endtask

    // receiver stall, redrawn every cycle
    always @(posedge i_clk) begin
        i_stall <= (($urandom % 100) < recv_idle_pct);
    end

    // compare accepted digest words against the oldest expectation
    always @(posedge i_clk) begin
        t_digest_beat want;
        if (i_rst_n && o_valid && !i_stall) begin
            if (digest_queue.size() == 0) begin
                report_mismatch("unexpected digest word", o_digest_word, '0);
            end else begin
                want = digest_queue.pop_front();
                if (o_digest_word !== want.word)
                    report_mismatch("digest_word", o_digest_word, want.word);
                if (o_word_index !== want.index)
                    report_mismatch("word_index", 64'(o_word_index), 64'(want.index));
                if (o_last_digest_word !== want.last)
                    report_mismatch("last_digest_word", 64'(o_last_digest_word), 64'(want.last));
            end
        end
    end

    // directed rows: empty message, "abc", extremes of the count and data fields
    t_stim_row directed [] = '{
        '{64'h0, 4'd0, 1'b1, 1'b1, 64'hcf83e1357eefb8bd},
        '{64'h6162630000000000, 4'd3, 1'b1, 1'b1, 64'hddaf35a193617aba},
        '{64'hffff_ffff_ffff_ffff, 4'd0, 1'b1, 1'b1, 64'hcf83e1357eefb8bd},
        '{64'h6162_63ff_ffff_ffff, 4'd3, 1'b1, 1'b1, 64'hddaf35a193617aba},
        '{64'hffff_ffff_ffff_ffff, 4'd8, 1'b1, 1'b0, 64'h0},
        '{64'h0123_4567_89ab_cdef, 4'd15, 1'b1, 1'b0, 64'h0},
        '{64'hffff_ffff_ffff_ffff, 4'd9, 1'b0, 1'b0, 64'h0},
        '{64'h0, 4'd0, 1'b0, 1'b0, 64'h0},
        '{64'haaaa_aaaa_aaaa_aaaa, 4'd1, 1'b1, 1'b0, 64'h0},
        '{64'h5555_5555_5555_5555, 4'd7, 1'b1, 1'b0, 64'h0},
        '{64'h8000_0000_0000_0001, 4'd2, 1'b1, 1'b0, 64'h0},
        '{64'hdead_beef_cafe_f00d, 4'd4, 1'b1, 1'b0, 64'h0},
        '{64'h1234_5678_9abc_def0, 4'd5, 1'b1, 1'b0, 64'h0},
        '{64'h0fed_cba9_8765_4321, 4'd6, 1'b1, 1'b0, 64'h0}
    };

    initial begin
        int unsigned words;
        restart_hash();
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed table; typed-in first digest words checked as well
        foreach (directed[r]) begin
            if (directed[r].has_digest0 && hash_state[0] == INIT_H[0] && block_fill == 0) begin
                wait_drained();
                send_word(directed[r].data, directed[r].count, directed[r].last);
                if (digest_queue[0].word !== directed[r].digest0)
                    report_mismatch("predicted digest", digest_queue[0].word,
                                    directed[r].digest0);
            end else begin
                send_word(directed[r].data, directed[r].count, directed[r].last);
            end
        end
        // boundary lengths: 14, 15 and 16 words before the last item
        send_message(14, 4'd8);
        send_message(15, 4'd0);
        send_message(15, 4'd8);
        send_message(16, 4'd5);
        wait_drained();

        // random messages in three idling phases
        for (int phase = 0; phase < 3; phase++) begin
            send_idle_pct = (phase == 0) ? 33 : (phase == 1) ? 62 : 0;
            recv_idle_pct = (phase == 0) ? 62 : (phase == 1) ? 33 : 0;
            for (int m = 0; m < 8; m++) begin
                words = ($urandom % 4 == 0) ? $urandom_range(14, 33) : $urandom_range(0, 8);
                send_message(words, 4'($urandom));
            end
        end
        wait_drained();
        repeat (300) @(posedge i_clk);

        if (error_count == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

    initial begin
        #20ms;
        $display("tb: failure");
        $finish;
    end

endmodule
